// ----- design/etf_int_list_decoder_core_defines.svh -----
// Assertion helpers for the integer list decoder.
// Both sample on aclk and are held off while aresetn is low.
`ifndef ETF_INT_LIST_DECODER_CORE_DEFINES_SVH
`define ETF_INT_LIST_DECODER_CORE_DEFINES_SVH

// Same-cycle implication.
`define ETFILD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("etfild: same-cycle check failed");

// Next-cycle implication.
`define ETFILD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("etfild: next-cycle check failed");

`endif

// ----- design/etfild_pkg.sv -----
`default_nettype none

package etfild_pkg;

    localparam logic [7:0] MAGIC_BYTE    = 8'd131;
    localparam logic [7:0] TAG_SMALL_INT = 8'd97;
    localparam logic [7:0] TAG_INT       = 8'd98;
    localparam logic [7:0] TAG_NIL       = 8'd106;
    localparam logic [7:0] TAG_STRING    = 8'd107;
    localparam logic [7:0] TAG_LIST      = 8'd108;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_LEN,
        PH_TAG,
        PH_SMALL,
        PH_INT,
        PH_STR,
        PH_NIL
    } phase_t;

    typedef enum logic [2:0] {
        ST_ELEM      = 3'd0,
        ST_ELEM_DONE = 3'd1,
        ST_DONE      = 3'd2,
        ST_BAD_MAGIC = 3'd3,
        ST_BAD_HDR   = 3'd4,
        ST_BAD_TAG   = 3'd5,
        ST_NO_NIL    = 3'd6,
        ST_TOO_LONG  = 3'd7
    } status_t;

    typedef struct packed {
        status_t                     status;
        logic signed [VALUE_W-1:0]   value;
        logic        [INDEX_W-1:0]   index;
        logic        [COUNT_W-1:0]   count;
    } res_t;

endpackage

`default_nettype wire

// ----- design/etfild_parser.sv -----
`default_nettype none

module etfild_parser #(
    parameter int MAX_ELEMENTS = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       byte_in,
    input  wire logic             first,
    output logic                  res_valid,
    output etfild_pkg::res_t      res
);
    import etfild_pkg::*;

    localparam int REM_W = $clog2(MAX_ELEMENTS + 1);

    phase_t                phase_reg, phase_next;
    logic                  list_mode_reg, list_mode_next;
    logic [REM_W-1:0]      remaining_reg, remaining_next;
    logic [REM_W-1:0]      total_len_reg, total_len_next;
    logic [1:0]            byte_pos_reg, byte_pos_next;
    logic [31:0]           accum_reg, accum_next;
    logic [INDEX_W-1:0]    elem_index_reg, elem_index_next;

    logic [31:0]           acc_shift;
    logic                  len_last;
    logic                  len_zero;
    logic                  too_long;
    logic                  rem_last;
    logic                  hdr_ok;
    logic                  elem_fire;
    logic [31:0]           elem_val;
    phase_t                elem_phase;

    assign acc_shift  = {accum_reg[23:0], byte_in};
    assign len_last   = byte_pos_reg == (list_mode_reg ? 2'd3 : 2'd1);
    assign len_zero   = acc_shift == 32'd0;
    assign too_long   = acc_shift > 32'(MAX_ELEMENTS);
    assign rem_last   = remaining_reg == REM_W'(1);
    assign hdr_ok     = (byte_in == TAG_STRING) || (byte_in == TAG_LIST);
    assign elem_phase = rem_last ? (list_mode_reg ? PH_NIL : PH_IDLE)
                                 : (list_mode_reg ? PH_TAG : PH_STR);

    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            if (first) begin
                phase_next = (byte_in == MAGIC_BYTE) ? PH_HDR : PH_IDLE;
            end else begin
                case (phase_reg)
                    PH_HDR: phase_next = hdr_ok ? PH_LEN : PH_IDLE;
                    PH_LEN: begin
                        if (len_last) begin
                            if (too_long) begin
                                phase_next = PH_IDLE;
                            end else if (len_zero) begin
                                phase_next = list_mode_reg ? PH_NIL : PH_IDLE;
                            end else begin
                                phase_next = list_mode_reg ? PH_TAG : PH_STR;
                            end
                        end
                    end
                    PH_STR, PH_SMALL: phase_next = elem_phase;
                    PH_TAG: begin
                        if (byte_in == TAG_SMALL_INT) begin
                            phase_next = PH_SMALL;
                        end else if (byte_in == TAG_INT) begin
                            phase_next = PH_INT;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_INT: begin
                        if (byte_pos_reg == 2'd3) begin
                            phase_next = elem_phase;
                        end
                    end
                    PH_NIL:  phase_next = PH_IDLE;
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        list_mode_next  = list_mode_reg;
        remaining_next  = remaining_reg;
        total_len_next  = total_len_reg;
        byte_pos_next   = byte_pos_reg;
        accum_next      = accum_reg;
        elem_index_next = elem_index_reg;
        res_valid       = 1'b0;
        res             = '0;
        elem_fire       = 1'b0;
        elem_val        = 32'd0;

        if (step) begin
            if (first) begin
                list_mode_next  = 1'b0;
                remaining_next  = '0;
                total_len_next  = '0;
                byte_pos_next   = 2'd0;
                accum_next      = 32'd0;
                elem_index_next = '0;
                if (byte_in != MAGIC_BYTE) begin
                    res_valid  = 1'b1;
                    res.status = ST_BAD_MAGIC;
                end
            end else begin
                case (phase_reg)
                    PH_HDR: begin
                        if (hdr_ok) begin
                            list_mode_next = byte_in == TAG_LIST;
                            byte_pos_next  = 2'd0;
                            accum_next     = 32'd0;
                        end else begin
                            res_valid  = 1'b1;
                            res.status = ST_BAD_HDR;
                        end
                    end
                    PH_LEN: begin
                        accum_next = acc_shift;
                        if (!len_last) begin
                            byte_pos_next = byte_pos_reg + 2'd1;
                        end else begin
                            byte_pos_next = 2'd0;
                            if (too_long) begin
                                res_valid  = 1'b1;
                                res.status = ST_TOO_LONG;
                            end else begin
                                total_len_next  = acc_shift[REM_W-1:0];
                                remaining_next  = acc_shift[REM_W-1:0];
                                elem_index_next = '0;
                                accum_next      = 32'd0;
                                if (len_zero && !list_mode_reg) begin
                                    res_valid  = 1'b1;
                                    res.status = ST_DONE;
                                end
                            end
                        end
                    end
                    PH_STR, PH_SMALL: begin
                        elem_fire = 1'b1;
                        elem_val  = {24'd0, byte_in};
                    end
                    PH_TAG: begin
                        if (byte_in == TAG_INT) begin
                            byte_pos_next = 2'd0;
                            accum_next    = 32'd0;
                        end else if (byte_in != TAG_SMALL_INT) begin
                            res_valid  = 1'b1;
                            res.status = ST_BAD_TAG;
                        end
                    end
                    PH_INT: begin
                        accum_next = acc_shift;
                        if (byte_pos_reg != 2'd3) begin
                            byte_pos_next = byte_pos_reg + 2'd1;
                        end else begin
                            byte_pos_next = 2'd0;
                            elem_fire     = 1'b1;
                            elem_val      = acc_shift;
                        end
                    end
                    PH_NIL: begin
                        res_valid = 1'b1;
                        if (byte_in != TAG_NIL) begin
                            res.status = ST_NO_NIL;
                        end else begin
                            res.status = ST_DONE;
                            res.count  = COUNT_W'(total_len_reg);
                        end
                    end
                    default: ;
                endcase
            end

            // A string's last element closes the message; a list still needs its NIL.
            if (elem_fire) begin
                elem_index_next = elem_index_reg + INDEX_W'(1);
                remaining_next  = remaining_reg - REM_W'(1);
                res_valid       = 1'b1;
                res.value       = elem_val;
                res.index       = elem_index_reg;
                if (rem_last && !list_mode_reg) begin
                    res.status = ST_ELEM_DONE;
                    res.count  = COUNT_W'(total_len_reg);
                end else begin
                    res.status = ST_ELEM;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            list_mode_reg  <= 1'b0;
            remaining_reg  <= '0;
            total_len_reg  <= '0;
            byte_pos_reg   <= 2'd0;
            accum_reg      <= 32'd0;
            elem_index_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            list_mode_reg  <= list_mode_next;
            remaining_reg  <= remaining_next;
            total_len_reg  <= total_len_next;
            byte_pos_reg   <= byte_pos_next;
            accum_reg      <= accum_next;
            elem_index_reg <= elem_index_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/etf_int_list_decoder_core.sv -----
// A word accepted into the input register is parsed once the output register is free; any
// result it causes is then registered in the output register and shown on m_tvalid.
// Throughput: one byte per cycle; the input stalls only while a result waits on m_tready.
// Reset: aresetn is synchronous and active low; it empties both word registers and
// returns the parser to idle, so bytes without the first flag are then ignored.
`default_nettype none

`include "etf_int_list_decoder_core_defines.svh"

module etf_int_list_decoder_core #(
    parameter int MAX_ELEMENTS = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic [0:0]  s_tuser,   // [0] first
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [31:0] value, [39:32] index, [48:40] count, rest 0
    output logic [2:0]       m_tuser    // [2:0] status
);
    import etfild_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        out_valid_reg;
    res_t        out_reg;

    logic        out_free;
    logic        step;
    logic        res_valid;
    res_t        res;

    // The input register takes a new word while a result waits unclaimed only if it is empty.
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    etfild_parser #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_in   (in_byte_reg),
        .first     (in_first_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.count, out_reg.index, out_reg.value};
    assign m_tuser  = out_reg.status;

    `ETFILD_ASSERT_NOW(a_stall_needs_word, !s_tready, in_valid_reg)
    `ETFILD_ASSERT_NEXT(a_held_word_kept, in_valid_reg && !out_free, in_valid_reg)
    `ETFILD_ASSERT_NOW(a_elem_no_count, m_tvalid && (m_tuser == ST_ELEM), m_tdata[48:40] == 9'd0)
    `ETFILD_ASSERT_NOW(a_error_zero_payload, m_tvalid && (m_tuser >= ST_BAD_MAGIC),
        m_tdata == 56'd0)

endmodule

`default_nettype wire
